// File: design/lzrle_pkg.sv
// ---------------------------------------------------------------------------
// lzrle_pkg
// Shared types and constants of the LZ/RLE byte decompressor.
// ---------------------------------------------------------------------------
package lzrle_pkg;

  localparam int unsigned HIST_DEPTH_DEFAULT = 1024;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic REG_EXPECTED_SIZE = 1'b0;

  localparam logic [7:0] CTRL_LIT_BASE  = 8'h80;
  localparam logic [7:0] CTRL_FILL_BASE = 8'hA0;
  localparam logic [7:0] CTRL_ZERO_BASE = 8'hE0;
  localparam logic [7:0] CTRL_ZERO_LONG = 8'hFF;

  typedef enum logic [2:0] {
    PH_AWAIT,
    PH_LITERAL,
    PH_FILLVAL,
    PH_ZCOUNT,
    PH_DISTLO
  } lzrle_phase_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_WRITE
  } lzrle_state_e;

endpackage

// File: design/lzrle_in_if.sv
// ---------------------------------------------------------------------------
// lzrle_in_if
// Compressed byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface lzrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_file;

  modport source (output valid, output in_byte, output new_file, input ready);
  modport sink (input valid, input in_byte, input new_file, output ready);
endinterface

// File: design/lzrle_out_if.sv
// ---------------------------------------------------------------------------
// lzrle_out_if
// Decompressed result channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface lzrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [8:0] run_length;
  logic       last_of_burst;
  logic       size_reached;
  logic       bad_distance;

  modport source (
    output valid, output out_byte, output run_length, output last_of_burst,
    output size_reached, output bad_distance, input ready
  );
  modport sink (
    input valid, input out_byte, input run_length, input last_of_burst,
    input size_reached, input bad_distance, output ready
  );
endinterface

// File: design/lzrle_ring.sv
// ---------------------------------------------------------------------------
// lzrle_ring
// History ring memory, one write port and one registered read port.
// ---------------------------------------------------------------------------
module lzrle_ring import lzrle_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HIST_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lzrle_cfg.sv
// ---------------------------------------------------------------------------
// lzrle_cfg
// APB register port holding the expected decompressed size.
// ---------------------------------------------------------------------------
module lzrle_cfg import lzrle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [31:0]        expected_size_o
);

  logic [31:0] expected_size_q, expected_size_d;

  assign pready = 1'b1;

  always_comb begin
    expected_size_d = expected_size_q;
    prdata          = '0;
    unique case (paddr[2])
      REG_EXPECTED_SIZE: begin
        prdata = expected_size_q;
        if (psel && penable && pwrite) begin
          expected_size_d = pwdata;
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_size_q <= '0;
    end else begin
      expected_size_q <= expected_size_d;
    end
  end

  assign expected_size_o = expected_size_q;

endmodule

// File: design/lzrle_core.sv
// ---------------------------------------------------------------------------
// lzrle_core
// Command parser and copy sequencer around the history ring.
// ---------------------------------------------------------------------------
module lzrle_core import lzrle_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HIST_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       expected_size_i,
  lzrle_in_if.sink          in_i,
  lzrle_out_if.source       out_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [7:0]        mem_rdata_i
);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [8:0] n);
    logic [32:0] s;
    s = {1'b0, a} + 33'(n);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  lzrle_state_e state_q, state_d;
  lzrle_phase_e ph_q, ph_d, ph_c;
  logic [7:0]    held_q, held_d;
  logic [4:0]    lit_q, lit_d;
  logic [31:0]   count_q, count_d, count_c, count_inc1;
  logic [AW-1:0] wptr_q, wptr_d, wptr_c, wptr_inc, src;
  logic [AW:0]   src_sum;
  logic [9:0]    dist_q, dist_d;
  logic [5:0]    len_q, len_d;
  logic          bad_q, bad_d;
  logic          rd_ok_q, rd_ok_d;
  logic [7:0]    fill_val_q, fill_val_d;
  logic [8:0]    fill_left_q, fill_left_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [8:0]    out_len_q, out_len_d;
  logic          out_last_q, out_last_d;
  logic          out_size_q, out_size_d;
  logic          out_bad_q, out_bad_d;

  logic          out_free, in_acc, fresh;
  logic          emit, fill_go;
  logic [7:0]    fill_v, b, copy_v;
  logic [8:0]    fill_n;

  assign b        = in_i.in_byte;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign fresh    = in_acc && in_i.new_file;

  // a new file clears parser, count and ring pointer ahead of its byte
  assign ph_c     = fresh ? PH_AWAIT : ph_q;
  assign count_c  = fresh ? '0 : count_q;
  assign wptr_c   = fresh ? '0 : wptr_q;
  assign wptr_inc = (wptr_c == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_c + AW'(1);
  assign count_inc1 = sat_add(count_c, 9'd1);

  assign src_sum = {1'b0, wptr_q} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(dist_q);
  assign src     = (src_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                   AW'(src_sum - (AW+1)'(HISTORY_DEPTH)) : src_sum[AW-1:0];
  assign copy_v  = rd_ok_q ? mem_rdata_i : 8'h00;

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    held_d      = held_q;
    lit_d       = lit_q;
    count_d     = count_q;
    wptr_d      = wptr_q;
    dist_d      = dist_q;
    len_d       = len_q;
    bad_d       = bad_q;
    rd_ok_d     = rd_ok_q;
    fill_val_d  = fill_val_q;
    fill_left_d = fill_left_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wptr_c;
    mem_wdata_o = b;
    mem_re_o    = 1'b0;
    mem_raddr_o = src;
    emit        = 1'b0;
    fill_go     = 1'b0;
    fill_v      = 8'h00;
    fill_n      = 9'd2;
    out_byte_d  = out_byte_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_size_d  = out_size_q;
    out_bad_d   = out_bad_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ph_d    = ph_c;
          count_d = count_c;
          wptr_d  = wptr_c;
          if (in_i.new_file) begin
            held_d = '0;
            lit_d  = '0;
          end
          unique case (ph_c)
            PH_AWAIT: begin
              if (count_c < expected_size_i) begin
                held_d = b;
                if (b < CTRL_LIT_BASE) begin
                  ph_d = PH_DISTLO;
                end else if (b < CTRL_FILL_BASE) begin
                  lit_d = b[4:0];
                  ph_d  = (b[4:0] != '0) ? PH_LITERAL : PH_AWAIT;
                end else if (b == CTRL_ZERO_LONG) begin
                  ph_d = PH_ZCOUNT;
                end else if (b >= CTRL_ZERO_BASE) begin
                  fill_go = 1'b1;
                  fill_n  = 9'(b[4:0]) + 9'd2;
                end else begin
                  ph_d = PH_FILLVAL;
                end
              end
            end
            PH_LITERAL: begin
              mem_we_o   = 1'b1;
              wptr_d     = wptr_inc;
              count_d    = count_inc1;
              emit       = 1'b1;
              out_byte_d = b;
              out_len_d  = 9'd1;
              out_last_d = 1'b1;
              out_size_d = count_inc1 >= expected_size_i;
              out_bad_d  = 1'b0;
              lit_d      = lit_q - 5'd1;
              if (lit_q == 5'd1) begin
                ph_d = PH_AWAIT;
              end
            end
            PH_FILLVAL: begin
              ph_d    = PH_AWAIT;
              fill_go = 1'b1;
              fill_v  = b;
              fill_n  = 9'(held_q[4:0]) + 9'd2;
            end
            PH_ZCOUNT: begin
              ph_d    = PH_AWAIT;
              fill_go = 1'b1;
              fill_n  = 9'(b) + 9'd2;
            end
            PH_DISTLO: begin
              ph_d    = PH_AWAIT;
              dist_d  = {held_q[1:0], b};
              len_d   = 6'(held_q[6:2]) + 6'd2;
              bad_d   = ({held_q[1:0], b} == 10'd0) ||
                        (32'({held_q[1:0], b}) > count_c);
              state_d = S_READ;
            end
            default: ph_d = PH_AWAIT;
          endcase
          if (fill_go) begin
            count_d     = sat_add(count_c, fill_n);
            emit        = 1'b1;
            out_byte_d  = fill_v;
            out_len_d   = fill_n;
            out_last_d  = 1'b1;
            out_size_d  = sat_add(count_c, fill_n) >= expected_size_i;
            out_bad_d   = 1'b0;
            fill_val_d  = fill_v;
            fill_left_d = fill_n;
            state_d     = S_FILL;
          end
        end
      end
      S_FILL: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = fill_val_q;
        wptr_d      = wptr_inc;
        fill_left_d = fill_left_q - 9'd1;
        if (fill_left_q == 9'd1) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        // entries never written since the last clear read as zero
        mem_re_o = 1'b1;
        rd_ok_d  = (count_q >= 32'(HISTORY_DEPTH)) || (src < wptr_q);
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = copy_v;
          wptr_d      = wptr_inc;
          count_d     = count_inc1;
          emit        = 1'b1;
          out_byte_d  = copy_v;
          out_len_d   = 9'd1;
          out_last_d  = (len_q == 6'd1);
          out_size_d  = count_inc1 >= expected_size_i;
          out_bad_d   = bad_q;
          len_d       = len_q - 6'd1;
          state_d     = (len_q == 6'd1) ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_AWAIT;
      held_q      <= '0;
      lit_q       <= '0;
      count_q     <= '0;
      wptr_q      <= '0;
      len_q       <= '0;
      fill_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      held_q      <= held_d;
      lit_q       <= lit_d;
      count_q     <= count_d;
      wptr_q      <= wptr_d;
      len_q       <= len_d;
      fill_left_q <= fill_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q     <= dist_d;
    bad_q      <= bad_d;
    rd_ok_q    <= rd_ok_d;
    fill_val_q <= fill_val_d;
    out_byte_q <= out_byte_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
    out_size_q <= out_size_d;
    out_bad_q  <= out_bad_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.run_length    = out_len_q;
  assign out_o.last_of_burst = out_last_q;
  assign out_o.size_reached  = out_size_q;
  assign out_o.bad_distance  = out_bad_q;

  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_WRITE)
    else $error("ring read not followed by copy write");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !mem_we_o)
    else $error("ring written during copy read");

  a_stall_holds_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && out_valid_q && !out_o.ready) |=>
      ($stable(wptr_q) && $stable(count_q)))
    else $error("copy advanced while output stalled");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> fill_left_q != '0)
    else $error("fill sweep with nothing left");

endmodule

// File: design/lz_rle_byte_decompressor.sv
// Literal byte: its item is registered at the output the next cycle.
// Setup bytes (control, distance) give no item; short zero fill control, fill value
// and count bytes start a fill: one item, then the ring write port writes its bytes.
// Back reference: each copied byte takes a ring read, then a write and item.
// Reset clears control state; the ring is not swept, bytes never written since
// the last clear read as zero, tracked against the produced byte count.
// ---------------------------------------------------------------------------
// lz_rle_byte_decompressor
// LZ77 decoder with run-length fills over a byte history ring.
// ---------------------------------------------------------------------------
module lz_rle_byte_decompressor import lzrle_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HIST_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  lzrle_in_if.sink           in_i,
  lzrle_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [31:0]   expected_size;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  lzrle_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .expected_size_o (expected_size)
  );

  lzrle_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .expected_size_i (expected_size),
    .in_i            (in_i),
    .out_o           (out_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  lzrle_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: bench/lz_rle_byte_decompressor_test.sv
// ---------------------------------------------------------------------------
// lz_rle_byte_decompressor_test
// Drives compressed byte streams into the decompressor and predicts every
// decoded item: literal runs, fills, zero fills and back references. It
// checks each output field in order and covers the size limit, stream
// restarts, ring wrap and flagged distances under random stalls on both sides.
// ---------------------------------------------------------------------------
module lz_rle_byte_decompressor_test;
  import lzrle_pkg::*;

  localparam int unsigned RING_DEPTH = HIST_DEPTH_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 320;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [8:0] run_length;
    logic       last_of_burst;
    logic       size_reached;
    logic       bad_distance;
  } decoded_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  lzrle_in_if in_ch ();
  lzrle_out_if out_ch ();

  lz_rle_byte_decompressor uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source)
  );

  // decoder shadow state
  lzrle_phase_e parse_state;
  logic [7:0] held_ctrl;
  logic [4:0] lits_left;
  logic [31:0] produced;
  logic [31:0] size_limit;
  logic [7:0] history [RING_DEPTH];
  int unsigned wr_ptr;

  decoded_t decoded_q[$];

  int errors = 0;
  int items_sent = 0;
  int items_checked = 0;
  int fills_seen = 0;
  int flagged_seen = 0;
  int unsigned cycles = 0;
  bit gaps_on = 1'b1;
  int stall_left = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still pending", cycles, decoded_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ---- prediction ----

  task automatic clear_stream();
    parse_state = PH_AWAIT;
    held_ctrl = '0;
    lits_left = '0;
    produced = '0;
    wr_ptr = 0;
    foreach (history[i]) history[i] = 8'h00;
  endtask

  function automatic void push_history(logic [7:0] v);
    history[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
  endfunction

  function automatic void count_bytes(int unsigned n);
    if (produced > 32'hFFFF_FFFF - n) produced = 32'hFFFF_FFFF;
    else produced = produced + n;
  endfunction

  function automatic decoded_t make_item(logic [7:0] v, logic [8:0] n, logic bad);
    decoded_t r;
    r.out_byte = v;
    r.run_length = n;
    r.last_of_burst = 1'b0;
    r.size_reached = (produced >= size_limit);
    r.bad_distance = bad;
    return r;
  endfunction

  function automatic decoded_t fill_run(logic [7:0] v, logic [8:0] n);
    for (int i = 0; i < n; i++) push_history(v);
    count_bytes(n);
    return make_item(v, n, 1'b0);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic nf);
    decoded_t burst[$];
    decoded_t r;
    logic [9:0] distance;
    int unsigned len;
    int unsigned src;
    logic bad;
    logic [7:0] v;
    if (nf) clear_stream();
    case (parse_state)
      PH_AWAIT: begin
        if (produced >= size_limit) return;
        held_ctrl = b;
        if (b < CTRL_LIT_BASE) begin
          parse_state = PH_DISTLO;
        end else if (b < CTRL_FILL_BASE) begin
          lits_left = b[4:0];
          parse_state = (lits_left != 0) ? PH_LITERAL : PH_AWAIT;
        end else if (b == CTRL_ZERO_LONG) begin
          parse_state = PH_ZCOUNT;
        end else if (b >= CTRL_ZERO_BASE) begin
          burst.push_back(fill_run(8'h00, {4'b0, b[4:0]} + 9'd2));
        end else begin
          parse_state = PH_FILLVAL;
        end
      end
      PH_LITERAL: begin
        push_history(b);
        count_bytes(1);
        burst.push_back(make_item(b, 9'd1, 1'b0));
        lits_left = lits_left - 5'd1;
        if (lits_left == 0) parse_state = PH_AWAIT;
      end
      PH_FILLVAL: begin
        parse_state = PH_AWAIT;
        burst.push_back(fill_run(b, {4'b0, held_ctrl[4:0]} + 9'd2));
      end
      PH_ZCOUNT: begin
        parse_state = PH_AWAIT;
        burst.push_back(fill_run(8'h00, {1'b0, b} + 9'd2));
      end
      PH_DISTLO: begin
        distance = {held_ctrl[1:0], b};
        len = int'(held_ctrl[6:2]) + 2;
        bad = (distance == 0) || (32'(distance) > produced);
        parse_state = PH_AWAIT;
        for (int i = 0; i < len; i++) begin
          src = (wr_ptr + RING_DEPTH - distance) % RING_DEPTH;
          v = history[src];
          push_history(v);
          count_bytes(1);
          burst.push_back(make_item(v, 9'd1, bad));
        end
      end
      default: parse_state = PH_AWAIT;
    endcase
    foreach (burst[i]) begin
      r = burst[i];
      r.last_of_burst = (i == burst.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  // ---- result checking ----

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    decoded_t e;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected item: out_byte %0h run_length %0d", out_ch.out_byte,
               out_ch.run_length);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        check_field("out_byte", e.out_byte, out_ch.out_byte);
        check_field("run_length", e.run_length, out_ch.run_length);
        check_field("last_of_burst", e.last_of_burst, out_ch.last_of_burst);
        check_field("size_reached", e.size_reached, out_ch.size_reached);
        check_field("bad_distance", e.bad_distance, out_ch.bad_distance);
        items_checked++;
        if (e.run_length > 1) fills_seen++;
        if (e.bad_distance) flagged_seen++;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---- drivers ----

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic nf);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.new_file <= nf;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    decode_byte(b, nf);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() > 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_expected_size(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_EXPECTED_SIZE);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    size_limit = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    check_field("expected_size", value, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_command(input bit restart);
    int kind;
    int n;
    int unsigned max_dist;
    logic [9:0] distance;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_byte(8'($urandom_range(0, 255)), restart || ($urandom_range(0, 7) == 0));
    end else if (kind < 43) begin
      max_dist = restart ? 0 : ((produced > 1023) ? 1023 : produced);
      if (max_dist == 0 || $urandom_range(0, 9) == 0) distance = 10'($urandom_range(0, 1023));
      else distance = 10'($urandom_range(1, max_dist));
      n = $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 0) n = n % 6;
      send_byte({1'b0, 5'(n), distance[9:8]}, restart);
      send_byte(distance[7:0], 1'b0);
    end else if (kind < 68) begin
      n = $urandom_range(0, 31);
      send_byte(CTRL_LIT_BASE | 8'(n), restart);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 83) begin
      send_byte(CTRL_FILL_BASE + 8'($urandom_range(0, 63)), restart);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 93) begin
      send_byte(CTRL_ZERO_BASE + 8'($urandom_range(0, 30)), restart);
    end else begin
      send_byte(CTRL_ZERO_LONG, restart);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---- tests ----

  task automatic test_ignored_after_reset();
    send_byte(8'h81, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hE3, 1'b0);
    wait_idle();
  endtask

  task automatic test_each_command();
    set_expected_size(32'hFFFF_FFFF);
    send_byte(8'h82, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CTRL_LIT_BASE, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(CTRL_ZERO_LONG, 1'b0);
    send_byte(8'hFF, 1'b0);
    // distance beyond the bytes produced so far
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    // distance zero
    send_byte(8'h04, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_idle();
  endtask

  task automatic test_size_limit();
    set_expected_size(32'd5);
    send_byte(8'h83, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    // copy runs to completion past the limit
    send_byte(8'h7C, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'hE1, 1'b1);
    send_byte(8'hE1, 1'b0);
    send_byte(8'hE1, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_unbounded(input int count);
    bit paused;
    int stop_at;
    set_expected_size(32'hFFFF_FFFF);
    paused = 1'b0;
    stop_at = items_sent + count;
    send_random_command(1'b1);
    while (items_sent < stop_at) begin
      if (!paused && items_sent > stop_at - count / 2) begin
        drain();
        paused = 1'b1;
      end
      send_random_command($urandom_range(0, 59) == 0);
    end
    wait_idle();
  endtask

  task automatic test_random_bounded(input int count);
    int stop_at;
    stop_at = items_sent + count;
    set_expected_size($urandom_range(1, 600));
    send_random_command(1'b1);
    while (items_sent < stop_at)
      send_random_command((produced >= size_limit) || ($urandom_range(0, 29) == 0));
    wait_idle();
    set_expected_size(32'd1);
    send_byte(CTRL_FILL_BASE, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h82, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_back_to_back(input int count);
    int stop_at;
    stop_at = items_sent + count;
    set_expected_size(32'hFFFF_FFFF);
    gaps_on = 1'b0;
    send_random_command(1'b1);
    while (items_sent < stop_at) send_random_command(1'b0);
    drain();
    gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.new_file = 1'b0;
    size_limit = '0;
    clear_stream();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_ignored_after_reset();
    test_each_command();
    test_size_limit();
    test_random_unbounded(130);
    test_random_bounded(100);
    test_random_back_to_back(70);

    $display("sent %0d compressed bytes; checked %0d decoded items", items_sent,
             items_checked);
    $display("of those %0d were fill runs and %0d came from flagged copies", fills_seen,
             flagged_seen);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d items never arrived", errors, decoded_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
